// ===== hw/rtl/pmw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmw_pkg
// shared constants and types for the paged memory walker
// ----------------------------------------------------------------------------
package pmw_pkg;
  localparam int OFFSET_BITS_DEF = 2;
  localparam int LEVELS_DEF = 3;
  localparam int VA_BITS_DEF = 8;
  localparam int FRAMES_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int IO_WORD_W = 32;
  localparam int VA_IN_W = 32;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;
endpackage
`default_nettype wire

// ===== hw/rtl/pmw_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmw_req_if
// request channel: opcode, virtual address and write word
// ----------------------------------------------------------------------------
interface pmw_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] virtual_address;
  logic [31:0] write_data;
  modport source (output valid, opcode, virtual_address, write_data, input ready);
  modport sink (input valid, opcode, virtual_address, write_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pmw_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmw_rsp_if
// response channel: status and read word
// ----------------------------------------------------------------------------
interface pmw_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] read_data;
  modport source (output valid, ok, read_data, input ready);
  modport sink (input valid, ok, read_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pmw_frame_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmw_frame_mem
// single-port synchronous memory, read data registered and valid in the cycle after the address
// ----------------------------------------------------------------------------
module pmw_frame_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/paged_memory_walker_with_eviction_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_memory_walker_with_eviction_top
// page table walk with demand paging over an internal frame memory
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | opcode, virtual_address, write_data
//  rsp     | out | ok, read_data
//
// a walk that hits reads and checks one table word per level; accept, the word
// access and the response follow, with an extra data state on a read.
// a fault runs a depth-first scan of the table tree, reading each frame word
// and finishing each node, then zeroes a new table, saves an evicted page word
// by word or restores a saved page word by word.
// after reset a clearing pass zeroes all FRAMES*2^OFFSET_BITS words of frame
// memory, during which req.ready is low. one request is handled at a time;
// a response waiting on rsp.ready holds the next request off.
// ----------------------------------------------------------------------------
module paged_memory_walker_with_eviction_top
  import pmw_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LEVELS      = LEVELS_DEF,
  parameter int VA_BITS     = VA_BITS_DEF,
  parameter int FRAMES      = FRAMES_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  pmw_req_if.sink   req,
  pmw_rsp_if.source rsp
);
  localparam int PW      = 1 << OFFSET_BITS;
  localparam int FW      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AW      = FW + OFFSET_BITS;
  localparam int PB      = VA_BITS - OFFSET_BITS;
  localparam int TB      = LEVELS * OFFSET_BITS;
  localparam int SW      = PB + OFFSET_BITS;
  localparam int DW      = (LEVELS > 1) ? $clog2(LEVELS + 1) : 1;
  localparam int CW      = AW + 1;
  localparam int SDEPTH  = 1 << SW;
  localparam int PAGES   = 1 << PB;

  typedef enum logic [15:0] {
    S_CLR   = 16'h0001, S_IDLE  = 16'h0002, S_WRD   = 16'h0004, S_WCHK  = 16'h0008,
    S_DRD   = 16'h0010, S_DCHK  = 16'h0020, S_DNEXT = 16'h0040, S_DECIDE = 16'h0080,
    S_EVRD  = 16'h0100, S_EVWR  = 16'h0200, S_FILL  = 16'h0400, S_SWRD = 16'h0800,
    S_LINK  = 16'h1000, S_ACC   = 16'h2000, S_ADAT  = 16'h4000, S_RSP  = 16'h8000
  } state_t;

  state_t state;

  // frame memory port
  logic                 m_we;
  logic [AW-1:0]        m_addr;
  logic [WORD_BITS-1:0] m_wdata, m_rdata;

  pmw_frame_mem #(.DEPTH(FRAMES * PW), .WIDTH(WORD_BITS)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  // swap store
  logic [WORD_BITS-1:0] swap_mem [SDEPTH];
  logic [WORD_BITS-1:0] swap_rdata;
  logic                 s_we;
  logic [SW-1:0]        s_addr;
  logic [PAGES-1:0]     saved;

  always_ff @(posedge clk) begin
    if (s_we) begin
      swap_mem[s_addr] <= m_rdata;
    end
    swap_rdata <= swap_mem[s_addr];
  end

  // request registers
  logic                 op;
  logic [TB-1:0]        tree;
  logic [OFFSET_BITS-1:0] offs;
  logic [WORD_BITS-1:0] wd;
  logic                 res_ok;
  logic [31:0]          res_data;

  // walk registers
  logic [DW-1:0]        lvl;
  logic [FW-1:0]        frame;
  logic [FW-1:0]        newf;
  logic [CW-1:0]        cnt;

  // search stack: frame, word index per depth
  logic [FW-1:0]          st_frame [LEVELS+1];
  logic [OFFSET_BITS:0]   st_idx   [LEVELS+1];
  logic [PB-1:0]          st_page;
  logic [DW-1:0]          dep;
  logic [DW-1:0]          dep_up, dep_dn;
  logic                   nonzero;

  logic                 have_empty;
  logic [FW-1:0]        e_frame, e_parent;
  logic [OFFSET_BITS-1:0] e_slot;
  logic [FW-1:0]        top;
  logic                 have_vic;
  logic [PB:0]          best;
  logic [FW-1:0]        v_frame, v_parent;
  logic [OFFSET_BITS-1:0] v_slot;
  logic [PB-1:0]        v_page;

  assign dep_up = dep + DW'(1);
  assign dep_dn = dep - DW'(1);

  logic [OFFSET_BITS-1:0] widx;
  logic [PB-1:0]          tpage;
  assign tpage = tree[PB-1:0];
  always_comb begin
    widx = tree[TB-1 -: OFFSET_BITS];
    for (int i = 0; i < LEVELS; i++) begin
      if (DW'(i) == lvl) widx = tree[(LEVELS-1-i)*OFFSET_BITS +: OFFSET_BITS];
    end
  end

  // cyclic distance of a candidate leaf page
  logic [PB-1:0] cand_page;
  logic [PB:0]   dd, de, cdist;
  assign cand_page = st_page;
  always_comb begin
    dd = (tpage > cand_page) ? {1'b0, tpage - cand_page} : {1'b0, cand_page - tpage};
    de = (PB+1)'(PAGES) - dd;
    cdist = (dd < de) ? dd : de;
  end

  logic [FW-1:0] cur_f;
  logic [OFFSET_BITS-1:0] cur_i;
  logic [WORD_BITS-1:0] ent;
  logic ent_ok;
  assign cur_f = st_frame[dep];
  assign cur_i = st_idx[dep][OFFSET_BITS-1:0];
  assign ent = m_rdata;
  assign ent_ok = (ent != '0) && (ent < WORD_BITS'(FRAMES));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RSP);
  assign rsp.ok = res_ok;
  assign rsp.read_data = res_data;

  always_comb begin
    m_we = 1'b0;
    m_addr = {frame, widx};
    m_wdata = '0;
    s_we = 1'b0;
    s_addr = {tpage, cnt[OFFSET_BITS-1:0]};
    case (state)
      S_CLR: begin
        m_we = 1'b1; m_addr = cnt[AW-1:0];
      end
      S_WRD: m_addr = {frame, widx};
      S_DRD: m_addr = {cur_f, cur_i};
      S_DECIDE: begin
        if (have_empty) begin
          m_we = 1'b1; m_addr = {e_parent, e_slot};
        end else if (!(32'(top) + 1 < FRAMES) && have_vic) begin
          m_we = 1'b1; m_addr = {v_parent, v_slot};
        end
      end
      S_EVRD: m_addr = {v_frame, cnt[OFFSET_BITS-1:0]};
      S_EVWR: begin
        s_we = 1'b1; s_addr = {v_page, cnt[OFFSET_BITS-1:0]};
        m_addr = {v_frame, cnt[OFFSET_BITS-1:0]};
      end
      S_SWRD: s_addr = {tpage, cnt[OFFSET_BITS-1:0]};
      S_FILL: begin
        m_addr = {newf, cnt[OFFSET_BITS-1:0]};
        if (32'(lvl) != LEVELS - 1) begin
          m_we = 1'b1;
        end else if (saved[tpage] && cnt[OFFSET_BITS]) begin
          m_we = 1'b1; m_wdata = swap_rdata;
          m_addr = {newf, cnt[OFFSET_BITS-1:0] - OFFSET_BITS'(1)};
        end
      end
      S_LINK: begin
        m_we = 1'b1; m_addr = {frame, widx}; m_wdata = WORD_BITS'(newf);
      end
      S_ACC: begin
        m_addr = {frame, offs};
        m_we = (op == OP_WRITE); m_wdata = wd;
      end
      S_ADAT: m_addr = {frame, offs};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      saved <= '0;
    end else begin
      case (state)
        S_CLR: begin
          cnt <= cnt + CW'(1);
          if (32'(cnt) == FRAMES * PW - 1) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          op <= req.opcode;
          tree <= req.virtual_address[OFFSET_BITS +: TB];
          offs <= req.virtual_address[OFFSET_BITS-1:0];
          wd <= WORD_BITS'($signed(req.write_data));
          frame <= '0; lvl <= '0;
          res_ok <= 1'b0; res_data <= '0;
          if (VA_BITS < 32 && (req.virtual_address >> VA_BITS) != 0) state <= S_RSP;
          else state <= S_WRD;
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (ent_ok) begin
            frame <= ent[FW-1:0];
            if (32'(lvl) == LEVELS - 1) state <= S_ACC;
            else begin lvl <= lvl + DW'(1); state <= S_WRD; end
          end else begin
            // fault: start depth-first scan at root
            dep <= '0; st_frame[0] <= '0; st_idx[0] <= '0; st_page <= '0;
            have_empty <= 1'b0; top <= '0; have_vic <= 1'b0; best <= '0;
            nonzero <= 1'b0;
            state <= S_DRD;
          end
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          // scanning word cur_i of cur_f
          if (ent_ok && dep < DW'(LEVELS)) begin
            // descend
            st_frame[dep_up] <= ent[FW-1:0];
            st_idx[dep_up] <= '0;
            st_page <= PB'({st_page, cur_i});
            if (ent[FW-1:0] > top) top <= ent[FW-1:0];
            dep <= dep_up;
            nonzero <= 1'b0;
            if (32'(dep) + 1 >= LEVELS) begin
              state <= S_DNEXT; // leaf, evaluate
            end else state <= S_DRD;
          end else begin
            if (ent != '0) nonzero <= 1'b1;
            st_idx[dep] <= st_idx[dep] + (OFFSET_BITS+1)'(1);
            if (st_idx[dep] == (OFFSET_BITS+1)'(PW - 1)) state <= S_DNEXT;
            else state <= S_DRD;
          end
        end
        S_DNEXT: begin
          // node at dep finished (leaf, or all words scanned)
          if (32'(dep) >= LEVELS) begin
            if (cdist > best) begin
              best <= cdist; have_vic <= 1'b1;
              v_frame <= cur_f; v_page <= st_page;
              v_parent <= st_frame[dep_dn];
              v_slot <= st_idx[dep_dn][OFFSET_BITS-1:0];
            end
          end else if (dep != '0 && cur_f != frame && !nonzero) begin
            have_empty <= 1'b1; e_frame <= cur_f;
            e_parent <= st_frame[dep_dn];
            e_slot <= st_idx[dep_dn][OFFSET_BITS-1:0];
          end
          if (dep == '0 || (32'(dep) < LEVELS && dep != '0 && cur_f != frame && !nonzero))
            state <= S_DECIDE;
          else begin
            dep <= dep_dn;
            st_page <= st_page >> OFFSET_BITS;
            nonzero <= 1'b1;
            st_idx[dep_dn] <= st_idx[dep_dn] + (OFFSET_BITS+1)'(1);
            if (st_idx[dep_dn] == (OFFSET_BITS+1)'(PW - 1)) state <= S_DNEXT;
            else state <= S_DRD;
          end
        end
        S_DECIDE: begin
          cnt <= '0;
          if (have_empty) begin newf <= e_frame; state <= S_FILL; end
          else if (32'(top) + 1 < FRAMES) begin newf <= top + FW'(1); state <= S_FILL; end
          else if (have_vic) begin
            newf <= v_frame; state <= S_EVRD;
          end else state <= S_RSP;
        end
        S_EVRD: state <= S_EVWR;
        S_EVWR: begin
          if (32'(cnt) == PW - 1) begin
            saved[v_page] <= 1'b1; cnt <= '0; state <= S_SWRD;
          end else begin
            cnt <= cnt + CW'(1); state <= S_EVRD;
          end
        end
        S_SWRD: state <= S_FILL;
        S_FILL: begin
          if (32'(lvl) != LEVELS - 1) begin
            cnt <= cnt + CW'(1);
            if (32'(cnt) == PW - 1) state <= S_LINK;
          end else if (!saved[tpage]) state <= S_LINK;
          else if (!cnt[OFFSET_BITS]) begin
            // flag bit marks that swap data for the previous word is ready
            cnt <= CW'({1'b1, cnt[OFFSET_BITS-1:0] + OFFSET_BITS'(1)}); state <= S_FILL;
          end else begin
            if (32'(cnt[OFFSET_BITS-1:0]) == 0) state <= S_LINK;
            else begin cnt <= CW'(cnt[OFFSET_BITS-1:0]); state <= S_SWRD; end
          end
        end
        S_LINK: begin
          frame <= newf;
          if (32'(lvl) == LEVELS - 1) state <= S_ACC;
          else begin lvl <= lvl + DW'(1); state <= S_WRD; end
        end
        S_ACC: begin
          res_ok <= 1'b1;
          state <= (op == OP_WRITE) ? S_RSP : S_ADAT;
        end
        S_ADAT: begin
          res_data <= 32'($signed(m_rdata));
          state <= S_RSP;
        end
        S_RSP: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
